FILE: rtl/lrupr_pkg.sv
package lrupr_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  localparam int CFG_W      = 5;
  localparam int PAGE_OUT_W = 16;
  localparam int CNT_OUT_W  = 5;
  localparam int TOTAL_W    = 16;

  localparam logic [CFG_W-1:0]   FRAME_COUNT_RST = 5'd16;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX       = 16'hFFFF;

  // Per-reference control broadcast to every cell of the stack
  typedef struct packed {
    logic step;    // a reference transaction is accepted this cycle
    logic hit;     // page found somewhere in the stack
    logic evict;   // miss with the stack at its limit
    logic append;  // miss with room left
  } cell_ctl_t;

endpackage

FILE: rtl/lrupr_cell.sv
module lrupr_cell #(
  parameter int IDX       = 0,
  parameter int OCC_W     = 5,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                  clk,
  input  lrupr_pkg::cell_ctl_t  ctl,
  input  logic [OCC_W-1:0]      occ,
  input  logic [PAGE_BITS-1:0]  page,
  input  logic [PAGE_BITS-1:0]  next_data,
  input  logic                  seen_in,
  output logic                  seen_out,
  output logic [PAGE_BITS-1:0]  data_out
);

  localparam logic [OCC_W-1:0] POS  = OCC_W'(IDX);
  localparam logic [OCC_W-1:0] POS1 = OCC_W'(IDX + 1);

  logic [PAGE_BITS-1:0] entry_r;
  logic [PAGE_BITS-1:0] entry_nxt;
  logic                 valid;
  logic                 seen;
  logic                 shift;
  logic                 load;

  assign valid    = POS < occ;
  assign seen     = seen_in | (valid && (entry_r == page));
  assign seen_out = seen;
  assign data_out = entry_r;

  // Close the gap left by the hit or the evicted entry: take the newer neighbour
  assign shift = ctl.step && (seen || ctl.evict) && (POS1 < occ);
  assign load  = ctl.step && (((POS1 == occ) && (ctl.hit || ctl.evict)) ||
                              ((POS == occ) && ctl.append));

  always_comb begin
    entry_nxt = entry_r;
    if (load) begin
      entry_nxt = page;
    end else if (shift) begin
      entry_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

FILE: rtl/lru_page_replacement.sv
// LRU page replacement stack.
// Input channel (in_valid/in_ready): one page reference per transaction, with
// in_last_ref marking the final reference of a string. Result channel
// (out_valid/out_ready): one transaction per reference carrying fault, the
// evicted page if any, the resident count and the saturating fault total.
// For each reference every cell of the stack compares its page at once, the
// hit ripples up the chain and each cell shifts or loads in the same edge.
// The result is registered and appears in the cycle after acceptance; one
// reference per cycle is sustained while out_ready stays high.
// A full output register parts the two sides: while the receiver stalls,
// the result waits and in_ready is low until it is taken.
// cfg_wr_en/cfg_wr_data write frame_count; 0 acts as 1 and values above
// FRAMES act as FRAMES. Write only while idle.
// Reset (rst_n low, synchronous) empties the stack, clears the fault total
// and sets frame_count to 16. After a reference flagged last the stack and
// total are cleared as well.
module lru_page_replacement #(
  parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lrupr_pkg::PAGE_OUT_W-1:0] in_page,
  input  logic                             in_last_ref,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_fault,
  output logic                             out_evicted_valid,
  output logic [lrupr_pkg::PAGE_OUT_W-1:0] out_evicted_page,
  output logic [lrupr_pkg::CNT_OUT_W-1:0]  out_resident_count,
  output logic [lrupr_pkg::TOTAL_W-1:0]    out_fault_total,
  input  logic                             cfg_wr_en,
  input  logic [lrupr_pkg::CFG_W-1:0]      cfg_wr_data
);

  localparam int OCC_W = $clog2(FRAMES + 1);
  localparam int PW    = lrupr_pkg::PAGE_OUT_W;

  logic [lrupr_pkg::CFG_W-1:0]   frame_count_r;
  logic [OCC_W-1:0]              occ_r, occ_nxt, occ_after;
  logic [lrupr_pkg::TOTAL_W-1:0] faults_r, faults_nxt, faults_after;
  logic [OCC_W-1:0]              lim;
  logic [PAGE_BITS-1:0]          page;
  logic [PAGE_BITS+PW-1:0]       page_ext;
  logic [PAGE_BITS+PW-1:0]       ev_ext;
  logic [OCC_W+lrupr_pkg::CNT_OUT_W-1:0] cnt_ext;
  lrupr_pkg::cell_ctl_t          ctl;
  logic [FRAMES:0]               seen;
  logic [PAGE_BITS-1:0]          data [FRAMES];

  logic                          out_valid_r;
  logic                          fault_r;
  logic                          ev_valid_r;
  logic [PW-1:0]                 ev_page_r;
  logic [lrupr_pkg::CNT_OUT_W-1:0] count_r;
  logic [lrupr_pkg::TOTAL_W-1:0] total_r;

  assign page_ext = {{PAGE_BITS{1'b0}}, in_page};
  assign page     = page_ext[PAGE_BITS-1:0];

  always_comb begin
    if (frame_count_r == '0) begin
      lim = OCC_W'(1);
    end else if (32'(frame_count_r) > FRAMES) begin
      lim = OCC_W'(FRAMES);
    end else begin
      lim = OCC_W'(frame_count_r);
    end
  end

  assign in_ready   = !out_valid_r || out_ready;
  assign ctl.step   = in_valid && in_ready;
  assign ctl.hit    = seen[FRAMES];
  assign ctl.evict  = !seen[FRAMES] && (occ_r >= lim);
  assign ctl.append = !seen[FRAMES] && (occ_r < lim);

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    logic [PAGE_BITS-1:0] nbr;
    if (i == FRAMES - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = data[i+1];
    end
    lrupr_cell #(
      .IDX       (i),
      .OCC_W     (OCC_W),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ_r),
      .page      (page),
      .next_data (nbr),
      .seen_in   (seen[i]),
      .seen_out  (seen[i+1]),
      .data_out  (data[i])
    );
  end

  assign occ_after    = ctl.append ? occ_r + OCC_W'(1) : occ_r;
  assign faults_after = (!ctl.hit && (faults_r != lrupr_pkg::TOTAL_MAX)) ?
                        faults_r + lrupr_pkg::TOTAL_W'(1) : faults_r;
  assign occ_nxt      = in_last_ref ? '0 : occ_after;
  assign faults_nxt   = in_last_ref ? '0 : faults_after;
  assign ev_ext       = {{PW{1'b0}}, data[0]};
  assign cnt_ext      = {{lrupr_pkg::CNT_OUT_W{1'b0}}, occ_after};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= lrupr_pkg::FRAME_COUNT_RST;
      occ_r         <= '0;
      faults_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frame_count_r <= cfg_wr_data;
      end
      if (ctl.step) begin
        occ_r       <= occ_nxt;
        faults_r    <= faults_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      fault_r    <= !ctl.hit;
      ev_valid_r <= ctl.evict;
      ev_page_r  <= ctl.evict ? ev_ext[PW-1:0] : '0;
      count_r    <= cnt_ext[lrupr_pkg::CNT_OUT_W-1:0];
      total_r    <= faults_after;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fault          = fault_r;
  assign out_evicted_valid  = ev_valid_r;
  assign out_evicted_page   = ev_page_r;
  assign out_resident_count = count_r;
  assign out_fault_total    = total_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(occ_r) <= FRAMES)
    else $error("occupancy beyond built depth");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step && in_last_ref |=> occ_r == '0 && faults_r == '0)
    else $error("last reference did not clear the stack");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step && ctl.append && !in_last_ref |=> occ_r == $past(occ_r) + OCC_W'(1))
    else $error("append did not grow the stack");

  a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step && ctl.evict |-> occ_r != '0)
    else $error("eviction from an empty stack");

  a_evict_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ev_valid_r |-> fault_r)
    else $error("eviction reported on a hit");

endmodule
